// ===== sv/cna_pkg.sv =====
// Shared types and codes for the complex number ALU.
package cna_pkg;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_CONJ = 3'd4
  } act_t;

  // Per-request control flags that travel down the pipe beside the data.
  typedef struct packed {
    logic [2:0] act;     // raw action code, unused codes kept as they came
    logic       sat;     // clamp flag of add, subtract or conjugate
    logic       neg_re;  // sign of the real magnitude
    logic       neg_im;  // sign of the imaginary magnitude
    logic       big_re;  // real magnitude known to exceed every part range
    logic       big_im;  // imaginary magnitude known to exceed every part range
    logic       dz;      // zero denominator
  } ctl_t;

endpackage

// ===== sv/cna_if.sv =====
// Request and response channel interfaces of the complex number ALU.
interface cna_req_if #(
  parameter int PART_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   action;
  logic signed [PART_WIDTH-1:0] a_real;
  logic signed [PART_WIDTH-1:0] a_imag;
  logic signed [PART_WIDTH-1:0] b_real;
  logic signed [PART_WIDTH-1:0] b_imag;

  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cna_rsp_if #(
  parameter int PART_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [PART_WIDTH-1:0] res_real;
  logic signed [PART_WIDTH-1:0] res_imag;
  logic                         div_zero;
  logic                         saturated;

  modport source (output valid, res_real, res_imag, div_zero, saturated, input ready);
  modport sink   (input valid, res_real, res_imag, div_zero, saturated, output ready);
endinterface

// ===== sv/cna_prod.sv =====
// First stage: partial products and the add, subtract and conjugate results.
module cna_prod
  import cna_pkg::*;
#(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              rst,
  cna_req_if.sink           req,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ctl_t              dn_ctl,
  output logic [W-1:0]      dn_q_re,
  output logic [W-1:0]      dn_q_im,
  output logic [2*W-1:0]    p_rr,
  output logic [2*W-1:0]    p_ii,
  output logic [2*W-1:0]    p_ri,
  output logic [2*W-1:0]    p_ir,
  output logic [2*W-1:0]    p_bb,
  output logic [2*W-1:0]    p_cc
);

  localparam int W2 = 2 * W;

  logic signed [W-1:0]  ar, ai, br, bi;
  logic signed [W2-1:0] m_rr, m_ii, m_ri, m_ir, m_bb, m_cc;
  logic [W:0]           sr, si;
  logic [W:0]           cr, ci;
  ctl_t                 ctl_next;

  // Returns {clamp flag, part} for a sum one bit wider than a part.
  function automatic logic [W:0] clamp_sum(input logic [W:0] v);
    if (v[W] != v[W-1]) begin
      return {1'b1, v[W], {(W-1){~v[W]}}};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  assign ar = req.a_real;
  assign ai = req.a_imag;
  assign br = req.b_real;
  assign bi = req.b_imag;

  assign m_rr = ar * br;
  assign m_ii = ai * bi;
  assign m_ri = ar * bi;
  assign m_ir = ai * br;
  assign m_bb = br * br;
  assign m_cc = bi * bi;

  always_comb begin
    unique case (req.action)
      ACT_ADD: begin
        sr = {ar[W-1], ar} + {br[W-1], br};
        si = {ai[W-1], ai} + {bi[W-1], bi};
      end
      ACT_SUB: begin
        sr = {ar[W-1], ar} - {br[W-1], br};
        si = {ai[W-1], ai} - {bi[W-1], bi};
      end
      ACT_CONJ: begin
        sr = {ar[W-1], ar};
        si = '0 - {ai[W-1], ai};
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
  end

  assign cr = clamp_sum(sr);
  assign ci = clamp_sum(si);

  always_comb begin
    ctl_next     = '0;
    ctl_next.act = req.action;
    ctl_next.sat = cr[W] | ci[W];
  end

  assign req.ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (req.ready) begin
      dn_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      dn_ctl        <= ctl_next;
      dn_q_re       <= cr[W-1:0];
      dn_q_im       <= ci[W-1:0];
      p_rr          <= m_rr;
      p_ii          <= m_ii;
      p_ri          <= m_ri;
      p_ir          <= m_ir;
      p_bb          <= m_bb;
      p_cc          <= m_cc;
    end
  end

endmodule

// ===== sv/cna_fold.sv =====
// Three stages: product sums, magnitudes, and divider or multiply preparation.
module cna_fold
  import cna_pkg::*;
#(
  parameter int W = 16,
  parameter int F = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  ctl_t           up_ctl,
  input  logic [W-1:0]   up_q_re,
  input  logic [W-1:0]   up_q_im,
  input  logic [2*W-1:0] p_rr,
  input  logic [2*W-1:0] p_ii,
  input  logic [2*W-1:0] p_ri,
  input  logic [2*W-1:0] p_ir,
  input  logic [2*W-1:0] p_bb,
  input  logic [2*W-1:0] p_cc,
  output logic           dn_valid,
  input  logic           dn_ready,
  output ctl_t           dn_ctl,
  output logic [2*W-1:0] dn_d,
  output logic [2*W-1:0] dn_rem_re,
  output logic [2*W-1:0] dn_rem_im,
  output logic [W-1:0]   dn_xl_re,
  output logic [W-1:0]   dn_xl_im,
  output logic [W-1:0]   dn_q_re,
  output logic [W-1:0]   dn_q_im
);

  localparam int W2 = 2 * W;
  localparam int XW = 2 * W + F;
  localparam int RW = W + F;

  // stage A: signed sums
  logic          va;
  ctl_t          ctl_a;
  logic [W-1:0]  q_re_a, q_im_a;
  logic [W2:0]   s_re_a, s_im_a;
  logic [W2-1:0] d_a;
  logic [W2:0]   s_re_next, s_im_next;
  logic          rdy_a;

  // stage B: magnitudes
  logic          vb;
  ctl_t          ctl_b;
  ctl_t          ctl_b_next;
  logic [W-1:0]  q_re_b, q_im_b;
  logic [W2-1:0] mag_re_b, mag_im_b, d_b;
  logic [W2:0]   abs_re, abs_im;
  logic          rdy_b;

  // stage C prep
  logic [W2-1:0] mq_re, mq_im;
  logic [XW-1:0] x_re, x_im;
  logic [RW-1:0] r0_re, r0_im;
  ctl_t          ctl_c_next;
  logic [W-1:0]  q_re_c_next, q_im_c_next;

  assign rdy_b    = !dn_valid || dn_ready;
  assign rdy_a    = !vb || rdy_b;
  assign up_ready = !va || rdy_a;

  always_comb begin
    unique case (up_ctl.act)
      ACT_MUL: begin
        s_re_next = {p_rr[W2-1], p_rr} - {p_ii[W2-1], p_ii};
        s_im_next = {p_ri[W2-1], p_ri} + {p_ir[W2-1], p_ir};
      end
      ACT_DIV: begin
        s_re_next = {p_rr[W2-1], p_rr} + {p_ii[W2-1], p_ii};
        s_im_next = {p_ir[W2-1], p_ir} - {p_ri[W2-1], p_ri};
      end
      default: begin
        s_re_next = '0;
        s_im_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) va       <= up_valid;
      if (rdy_a)    vb       <= va;
      if (rdy_b)    dn_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      ctl_a  <= up_ctl;
      q_re_a <= up_q_re;
      q_im_a <= up_q_im;
      s_re_a <= s_re_next;
      s_im_a <= s_im_next;
      d_a    <= p_bb + p_cc;  // both squares nonnegative, sum fits
    end
  end

  // |sum| never exceeds 2^(2W-1), so the magnitude fits 2W bits
  assign abs_re = s_re_a[W2] ? ('0 - s_re_a) : s_re_a;
  assign abs_im = s_im_a[W2] ? ('0 - s_im_a) : s_im_a;

  always_comb begin
    ctl_b_next        = ctl_a;
    ctl_b_next.neg_re = s_re_a[W2];
    ctl_b_next.neg_im = s_im_a[W2];
    ctl_b_next.dz     = (d_a == '0);
  end

  always_ff @(posedge clk) begin
    if (va && rdy_a) begin
      ctl_b        <= ctl_b_next;
      q_re_b       <= q_re_a;
      q_im_b       <= q_im_a;
      mag_re_b     <= abs_re[W2-1:0];
      mag_im_b     <= abs_im[W2-1:0];
      d_b          <= d_a;
    end
  end

  assign mq_re = mag_re_b >> F;
  assign mq_im = mag_im_b >> F;
  assign x_re  = XW'(mag_re_b) << F;
  assign x_im  = XW'(mag_im_b) << F;
  assign r0_re = x_re[XW-1:W];
  assign r0_im = x_im[XW-1:W];

  always_comb begin
    ctl_c_next  = ctl_b;
    q_re_c_next = q_re_b;
    q_im_c_next = q_im_b;
    unique case (ctl_b.act)
      ACT_MUL: begin
        ctl_c_next.big_re = |mq_re[W2-1:W];
        ctl_c_next.big_im = |mq_im[W2-1:W];
        q_re_c_next       = mq_re[W-1:0];
        q_im_c_next       = mq_im[W-1:0];
      end
      ACT_DIV: begin
        // quotient reaches 2^W exactly when the top dividend part is >= D
        ctl_c_next.big_re = (XW'(r0_re) >= XW'(d_b));
        ctl_c_next.big_im = (XW'(r0_im) >= XW'(d_b));
        q_re_c_next       = '0;
        q_im_c_next       = '0;
      end
      default: begin
        ctl_c_next.big_re = 1'b0;
        ctl_c_next.big_im = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vb && rdy_b) begin
      dn_ctl    <= ctl_c_next;
      dn_d      <= d_b;
      dn_rem_re <= W2'(r0_re);
      dn_rem_im <= W2'(r0_im);
      dn_xl_re  <= x_re[W-1:0];
      dn_xl_im  <= x_im[W-1:0];
      dn_q_re   <= q_re_c_next;
      dn_q_im   <= q_im_c_next;
    end
  end

endmodule

// ===== sv/cna_div_step.sv =====
// One restoring-division stage: one quotient bit for the real and imaginary parts.
module cna_div_step
  import cna_pkg::*;
#(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  ctl_t           up_ctl,
  input  logic [2*W-1:0] up_d,
  input  logic [2*W-1:0] up_rem_re,
  input  logic [2*W-1:0] up_rem_im,
  input  logic [W-1:0]   up_xl_re,
  input  logic [W-1:0]   up_xl_im,
  input  logic [W-1:0]   up_q_re,
  input  logic [W-1:0]   up_q_im,
  output logic           dn_valid,
  input  logic           dn_ready,
  output ctl_t           dn_ctl,
  output logic [2*W-1:0] dn_d,
  output logic [2*W-1:0] dn_rem_re,
  output logic [2*W-1:0] dn_rem_im,
  output logic [W-1:0]   dn_xl_re,
  output logic [W-1:0]   dn_xl_im,
  output logic [W-1:0]   dn_q_re,
  output logic [W-1:0]   dn_q_im
);

  localparam int W2 = 2 * W;

  logic [W2-1:0] t_re, t_im;
  logic          ge_re, ge_im;
  logic          is_div;

  // remainder stays below D <= 2^(2W-1), so the shifted value fits 2W bits
  assign t_re   = {up_rem_re[W2-2:0], up_xl_re[W-1]};
  assign t_im   = {up_rem_im[W2-2:0], up_xl_im[W-1]};
  assign ge_re  = (t_re >= up_d);
  assign ge_im  = (t_im >= up_d);
  assign is_div = (up_ctl.act == ACT_DIV);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_ctl   <= up_ctl;
      dn_d     <= up_d;
      dn_xl_re <= up_xl_re << 1;
      dn_xl_im <= up_xl_im << 1;
      if (is_div) begin
        dn_rem_re <= ge_re ? (t_re - up_d) : t_re;
        dn_rem_im <= ge_im ? (t_im - up_d) : t_im;
        dn_q_re   <= {up_q_re[W-2:0], ge_re};
        dn_q_im   <= {up_q_im[W-2:0], ge_im};
      end else begin
        dn_rem_re <= up_rem_re;
        dn_rem_im <= up_rem_im;
        dn_q_re   <= up_q_re;
        dn_q_im   <= up_q_im;
      end
    end
  end

endmodule

// ===== sv/cna_final.sv =====
// Last stage: signs, clamping, zero-denominator handling and the response register.
module cna_final
  import cna_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  output logic         up_ready,
  input  ctl_t         up_ctl,
  input  logic [W-1:0] up_q_re,
  input  logic [W-1:0] up_q_im,
  cna_rsp_if.source    rsp
);

  logic [W:0]   c_re, c_im;
  logic [W-1:0] re_next, im_next;
  logic         dz_next, sat_next;

  // Returns {clamp flag, part} for a sign and a magnitude.
  function automatic logic [W:0] clamp_mag(input logic neg, input logic big,
                                           input logic [W-1:0] q);
    if (!neg) begin
      if (big || q[W-1]) begin
        return {1'b1, 1'b0, {(W-1){1'b1}}};
      end
      return {1'b0, q};
    end
    if (big || (q[W-1] && (|q[W-2:0]))) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end
    return {1'b0, W'('0 - q)};
  endfunction

  assign c_re = clamp_mag(up_ctl.neg_re, up_ctl.big_re, up_q_re);
  assign c_im = clamp_mag(up_ctl.neg_im, up_ctl.big_im, up_q_im);

  always_comb begin
    unique case (up_ctl.act)
      ACT_ADD, ACT_SUB, ACT_CONJ: begin
        re_next  = up_q_re;
        im_next  = up_q_im;
        dz_next  = 1'b0;
        sat_next = up_ctl.sat;
      end
      ACT_MUL: begin
        re_next  = c_re[W-1:0];
        im_next  = c_im[W-1:0];
        dz_next  = 1'b0;
        sat_next = c_re[W] | c_im[W];
      end
      ACT_DIV: begin
        re_next  = up_ctl.dz ? '0 : c_re[W-1:0];
        im_next  = up_ctl.dz ? '0 : c_im[W-1:0];
        dz_next  = up_ctl.dz;
        sat_next = !up_ctl.dz && (c_re[W] | c_im[W]);
      end
      default: begin
        re_next  = '0;
        im_next  = '0;
        dz_next  = 1'b0;
        sat_next = 1'b0;
      end
    endcase
  end

  assign up_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (up_ready) begin
      rsp.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rsp.res_real  <= re_next;
      rsp.res_imag  <= im_next;
      rsp.div_zero  <= dz_next;
      rsp.saturated <= sat_next;
    end
  end

endmodule

// ===== sv/complex_number_alu_core.sv =====
// Complex number ALU top level: add, subtract, multiply, divide, conjugate in Q format.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    action, a_real, a_imag, b_real, b_imag
//   rsp      out  valid/ready    res_real, res_imag, div_zero, saturated
//
// Throughput is one request per cycle while the response channel is not stalled;
// the pipe is the product stage, three fold stages, one restoring-division stage
// per quotient bit and the response register. The division chain sets the depth.
// Every action runs through the whole pipe, so responses leave in order.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage holds while the next one is full and stalled; empty stages
// keep filling, so a stalled response does not block new requests until
// the whole pipe is full.
module complex_number_alu_core
  import cna_pkg::*;
#(
  parameter int PART_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic      clk,
  input  logic      rst,
  cna_req_if.sink   req,
  cna_rsp_if.source rsp
);

  localparam int W  = PART_WIDTH;
  localparam int W2 = 2 * PART_WIDTH;

  // product stage outputs
  logic          v1, r1;
  ctl_t          ctl1;
  logic [W-1:0]  q_re1, q_im1;
  logic [W2-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;

  // division chain taps: entry 0 is the fold output, entry W the last step
  logic          dv   [W+1];
  logic          drdy [W+1];
  ctl_t          dctl [W+1];
  logic [W2-1:0] dd   [W+1];
  logic [W2-1:0] drre [W+1];
  logic [W2-1:0] drim [W+1];
  logic [W-1:0]  dxre [W+1];
  logic [W-1:0]  dxim [W+1];
  logic [W-1:0]  dqre [W+1];
  logic [W-1:0]  dqim [W+1];

  cna_prod #(.W(W)) u_prod (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .dn_valid (v1),
    .dn_ready (r1),
    .dn_ctl   (ctl1),
    .dn_q_re  (q_re1),
    .dn_q_im  (q_im1),
    .p_rr     (p_rr),
    .p_ii     (p_ii),
    .p_ri     (p_ri),
    .p_ir     (p_ir),
    .p_bb     (p_bb),
    .p_cc     (p_cc)
  );

  cna_fold #(.W(W), .F(FRAC_BITS)) u_fold (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (v1),
    .up_ready  (r1),
    .up_ctl    (ctl1),
    .up_q_re   (q_re1),
    .up_q_im   (q_im1),
    .p_rr      (p_rr),
    .p_ii      (p_ii),
    .p_ri      (p_ri),
    .p_ir      (p_ir),
    .p_bb      (p_bb),
    .p_cc      (p_cc),
    .dn_valid  (dv[0]),
    .dn_ready  (drdy[0]),
    .dn_ctl    (dctl[0]),
    .dn_d      (dd[0]),
    .dn_rem_re (drre[0]),
    .dn_rem_im (drim[0]),
    .dn_xl_re  (dxre[0]),
    .dn_xl_im  (dxim[0]),
    .dn_q_re   (dqre[0]),
    .dn_q_im   (dqim[0])
  );

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < W; i++) begin : g_div
    cna_div_step #(.W(W)) u_step (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (dv[i]),
      .up_ready  (drdy[i]),
      .up_ctl    (dctl[i]),
      .up_d      (dd[i]),
      .up_rem_re (drre[i]),
      .up_rem_im (drim[i]),
      .up_xl_re  (dxre[i]),
      .up_xl_im  (dxim[i]),
      .up_q_re   (dqre[i]),
      .up_q_im   (dqim[i]),
      .dn_valid  (dv[i+1]),
      .dn_ready  (drdy[i+1]),
      .dn_ctl    (dctl[i+1]),
      .dn_d      (dd[i+1]),
      .dn_rem_re (drre[i+1]),
      .dn_rem_im (drim[i+1]),
      .dn_xl_re  (dxre[i+1]),
      .dn_xl_im  (dxim[i+1]),
      .dn_q_re   (dqre[i+1]),
      .dn_q_im   (dqim[i+1])
    );
  end

  cna_final #(.W(W)) u_final (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dv[W]),
    .up_ready (drdy[W]),
    .up_ctl   (dctl[W]),
    .up_q_re  (dqre[W]),
    .up_q_im  (dqim[W]),
    .rsp      (rsp)
  );

`ifndef SYNTHESIS
  localparam logic [W-1:0] PART_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] PART_MIN = {1'b1, {(W-1){1'b0}}};

  // an empty response register means every stage can take a request
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("request refused with the response register empty");

  a_dz_zero_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.div_zero |->
      rsp.res_real == '0 && rsp.res_imag == '0 && !rsp.saturated)
    else $error("zero-denominator response not cleared");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.saturated |->
      rsp.res_real == PART_MAX || rsp.res_real == PART_MIN ||
      rsp.res_imag == PART_MAX || rsp.res_imag == PART_MIN)
    else $error("saturation flag with no part at a bound");

  a_dz_only_divide: assert property (@(posedge clk) disable iff (rst)
    dv[W] && dctl[W].dz && drdy[W] |=> rsp.valid &&
      (rsp.div_zero == ($past(dctl[W].act) == ACT_DIV)))
    else $error("divide-by-zero flag lost or raised on another action");
`endif

endmodule
